// File: hdl/abt_pkg.sv
// shared types and constants for the address blocklist table
`timescale 1ns / 1ps

package abt_pkg;

	localparam int ENTRIES    = 64;
	localparam int KEY_BYTES  = 32;
	localparam int STAMP_BITS = 32;

	localparam int KEY_BITS = KEY_BYTES * 8;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int LEN_W    = 6;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int NOW_W    = 32;
	localparam int WORD_W   = 64;

	typedef enum logic [1:0] {
		MODE_CHECK = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic                  act;
		logic                  found;
		logic [IDX_W-1:0]      hit_idx;
		logic [STAMP_BITS-1:0] min_stamp;
		logic [IDX_W-1:0]      min_idx;
	} tok_t;

	// write command broadcast to all cells
	typedef struct packed {
		logic             entry;
		logic             stamp_only;
		logic [IDX_W-1:0] idx;
	} wr_t;

endpackage

// File: hdl/abt_cell.sv
// one table entry with its compare and oldest-search step
`timescale 1ns / 1ps

module abt_cell
	import abt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      cell_idx,
	input  logic [CNT_W-1:0]      count,
	input  logic [KEY_BITS-1:0]   q_key,
	input  logic [LEN_W-1:0]      q_len,
	input  logic [STAMP_BITS-1:0] q_stamp,
	input  wr_t                   wr,
	input  tok_t                  tok_in,
	output tok_t                  tok_out
);

	logic [KEY_BITS-1:0]   key_q;
	logic [LEN_W-1:0]      len_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  hit;
	logic                  older;
	logic                  sel;
	logic                  act_q;
	logic                  found_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [STAMP_BITS-1:0] min_stamp_q;
	logic [IDX_W-1:0]      min_idx_q;

	assign sel   = (wr.idx == cell_idx);
	assign hit   = (CNT_W'(cell_idx) < count) && (len_q == q_len) && (key_q == q_key);
	assign older = (stamp_q < tok_in.min_stamp);

	always_ff @(posedge clk) begin
		if (wr.entry && sel) begin
			key_q   <= q_key;
			len_q   <= q_len;
			stamp_q <= q_stamp;
		end else if (wr.stamp_only && sel) begin
			stamp_q <= q_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_in.act;
		end
	end

	// first hit along the chain wins, strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		found_q     <= tok_in.found | hit;
		hit_idx_q   <= tok_in.found ? tok_in.hit_idx : cell_idx;
		min_stamp_q <= older ? stamp_q : tok_in.min_stamp;
		min_idx_q   <= older ? cell_idx : tok_in.min_idx;
	end

	assign tok_out = {act_q, found_q, hit_idx_q, min_stamp_q, min_idx_q};

endmodule

// File: hdl/address_blocklist_table.sv
// address blocklist table: top level with control and a chain of entry cells
// a word passes the input registers, the search token walks the cell chain, then the result registers
// a new word is only taken once the previous search has finished and its result is registered
// a new word is taken while the previous result still waits on out_stall
// reset: entry count cleared and control idle; entry contents stay undefined until written
`timescale 1ns / 1ps

module address_blocklist_table
	import abt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [WORD_W-1:0]  key_word0,
	input  logic [WORD_W-1:0]  key_word1,
	input  logic [WORD_W-1:0]  key_word2,
	input  logic [WORD_W-1:0]  key_word3,
	input  logic [LEN_W-1:0]   key_length,
	input  logic [NOW_W-1:0]   now,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               matched,
	output logic               evicted,
	output logic [SLOT_W-1:0]  slot,
	output logic [COUNT_W-1:0] entry_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic                  launch_q;
	logic [CNT_W-1:0]      count_q;
	mode_t                 mode_q;
	logic                  ok_q;
	logic [KEY_BITS-1:0]   qkey_q;
	logic [LEN_W-1:0]      qlen_q;
	logic [STAMP_BITS-1:0] qstamp_q;
	tok_t                  fin_q;
	logic                  out_valid_q;
	logic                  matched_q;
	logic                  evicted_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [COUNT_W-1:0]    entry_count_q;

	logic [4*WORD_W-1:0]   key_all;
	logic [KEY_BITS-1:0]   key_masked;
	logic                  accept;
	logic                  go;
	tok_t                  tok_start;
	tok_t                  chain [ENTRIES+1];
	wr_t                   wr;
	logic                  f_matched;
	logic                  f_evicted;
	logic [IDX_W-1:0]      f_idx;
	logic [CNT_W-1:0]      f_count;

	assign key_all = {key_word3, key_word2, key_word1, key_word0};

	always_comb begin
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_masked[b*8 +: 8] = (LEN_W'(b) < key_length) ? key_all[b*8 +: 8] : 8'd0;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign go       = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	assign tok_start.act       = launch_q;
	assign tok_start.found     = 1'b0;
	assign tok_start.hit_idx   = '0;
	assign tok_start.min_stamp = '1;
	assign tok_start.min_idx   = '0;
	assign chain[0]            = tok_start;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		abt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.count    (count_q),
			.q_key    (qkey_q),
			.q_len    (qlen_q),
			.q_stamp  (qstamp_q),
			.wr       (wr),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	// final decision once the token has passed every cell
	always_comb begin
		f_matched      = 1'b0;
		f_evicted      = 1'b0;
		f_idx          = '0;
		f_count        = count_q;
		wr.entry       = 1'b0;
		wr.stamp_only  = 1'b0;
		wr.idx         = '0;
		case (mode_q)
			MODE_CLEAR: begin
				f_count = '0;
			end
			MODE_CHECK, MODE_ADD: begin
				if (ok_q) begin
					if (fin_q.found) begin
						f_matched     = 1'b1;
						f_idx         = fin_q.hit_idx;
						wr.stamp_only = go && (mode_q == MODE_ADD);
					end else if (mode_q == MODE_ADD) begin
						if (count_q < CNT_W'(ENTRIES)) begin
							f_idx   = IDX_W'(count_q);
							f_count = count_q + CNT_W'(1);
						end else begin
							f_idx     = fin_q.min_idx;
							f_evicted = 1'b1;
						end
						wr.entry = go;
					end
				end
			end
			default: begin
				f_count = count_q;
			end
		endcase
		wr.idx = f_idx;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(mode);
			ok_q     <= (key_length != '0) && (key_length <= LEN_W'(KEY_BYTES));
			qkey_q   <= key_masked;
			qlen_q   <= key_length;
			qstamp_q <= STAMP_BITS'(now);
		end
		if (chain[ENTRIES].act) begin
			fin_q <= chain[ENTRIES];
		end
		if (go) begin
			matched_q     <= f_matched;
			evicted_q     <= f_evicted;
			slot_q        <= SLOT_W'(f_idx);
			entry_count_q <= COUNT_W'(f_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= accept;
			if (out_valid_q && !out_stall && !go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[ENTRIES].act) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (go) begin
						count_q     <= f_count;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign matched     = matched_q;
	assign evicted     = evicted_q;
	assign slot        = slot_q;
	assign entry_count = entry_count_q;

endmodule

// File: hdl/abt_checker.sv
// port-level checks for the address blocklist table, bound to the top level
`timescale 1ns / 1ps

module abt_checker
	import abt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               matched,
	input logic               evicted,
	input logic [SLOT_W-1:0]  slot,
	input logic [COUNT_W-1:0] entry_count
);

	// a taken word keeps the input stalled while the search runs
	a_stall_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a word was taken");

	// a stalled result word holds its valid, slot and entry count
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot) && $stable(entry_count))
		else $error("result word changed while stalled");

	// a hit never also replaces an entry
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && evicted))
		else $error("matched and evicted both set");

	// replacement only happens on a full table
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> entry_count == COUNT_W'(ENTRIES))
		else $error("eviction with table not full");

	// a hit needs at least one entry, and the count never exceeds the table size
	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= COUNT_W'(ENTRIES)) && (!matched || entry_count != '0))
		else $error("entry count inconsistent with result");

endmodule

bind address_blocklist_table abt_checker u_abt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.matched     (matched),
	.evicted     (evicted),
	.slot        (slot),
	.entry_count (entry_count)
);
